// ===== rtl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque with remove-by-value.
`timescale 1ns / 1ps

package bdq_pkg;

	// Storage geometry
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int VALUE_W    = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Request operation codes
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_REMOVE     = 3'd4;
	localparam logic [2:0] MODE_SEARCH     = 3'd5;

	// Response status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// Per-cell command broadcast along the row
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_POP_FRONT,
		CELL_POP_BACK,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                op;
		logic [DATA_WIDTH-1:0]   key;
	} cell_ctrl_t;

endpackage

// ===== rtl/bounded_deque_with_remove_by_value.sv =====
// Top level of the bounded deque with remove-by-value and search.
`timescale 1ns / 1ps

// Ordered store of up to 16 values held in a row of cells, front at cell 0.
// Every request (push front/back, pop front/back, remove first match, search)
// is decoded combinationally: all cells compare the key and shift toward their
// neighbor in the same cycle, and the response is registered, so it appears
// on the output the cycle after the request is accepted. A new request is
// taken every cycle as long as the response register is free or being
// drained; in_stall is high only while a response waits under out_stall.
// The rate is one request per cycle while in_stall is low.
module bounded_deque_with_remove_by_value
	import bdq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [VALUE_W-1:0] data_out,
	output logic [CNT_W-1:0]   entry_count
);

	logic                  accept;
	logic [DATA_WIDTH-1:0] key;
	logic                  full;
	logic                  empty;
	logic                  found;
	cell_ctrl_t            ctrl;

	logic [DATA_WIDTH-1:0] cell_value [CAPACITY];
	logic                  cell_valid [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_tail  [CAPACITY];
	logic                  hit        [CAPACITY+1];

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_next;
	logic [1:0]            status_next;
	logic [DATA_WIDTH-1:0] data_next;
	logic [DATA_WIDTH-1:0] back_data;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [CNT_W-1:0]      entry_count_q;

	// Handshake
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign key      = value[DATA_WIDTH-1:0];
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign found    = hit[CAPACITY];

	// Row of cells
	assign hit[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lv;
		logic                  lval;
		logic [DATA_WIDTH-1:0] rv;
		logic                  rval;

		if (i == 0) begin : g_first
			assign lv   = key;
			assign lval = 1'b1;
		end else begin : g_mid_l
			assign lv   = cell_value[i-1];
			assign lval = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rv   = '0;
			assign rval = 1'b0;
		end else begin : g_mid_r
			assign rv   = cell_value[i+1];
			assign rval = cell_valid[i+1];
		end

		bdq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_value  (lv),
			.left_valid  (lval),
			.right_value (rv),
			.right_valid (rval),
			.hit_in      (hit[i]),
			.hit_out     (hit[i+1]),
			.tail_value  (cell_tail[i]),
			.value_q     (cell_value[i]),
			.valid_q     (cell_valid[i])
		);
	end

	// Only the last occupied cell drives a nonzero tail value
	always_comb begin
		back_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_data = back_data | cell_tail[i];
		end
	end

	// Request decode: cell command, status, popped data and new count
	always_comb begin
		ctrl.op     = CELL_HOLD;
		ctrl.key    = key;
		status_next = ST_OK;
		data_next   = '0;
		count_next  = count_q;
		unique case (mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					ctrl.op    = (mode == MODE_PUSH_FRONT) ? CELL_PUSH_FRONT
					                                       : CELL_PUSH_BACK;
					count_next = count_q + 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					ctrl.op    = CELL_POP_FRONT;
					data_next  = cell_value[0];
					count_next = count_q - 1'b1;
				end
			end
			MODE_POP_BACK: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					ctrl.op    = CELL_POP_BACK;
					data_next  = back_data;
					count_next = count_q - 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (!found) begin
					status_next = ST_MISSING;
				end else begin
					ctrl.op    = CELL_REMOVE;
					count_next = count_q - 1'b1;
				end
			end
			MODE_SEARCH: begin
				if (!found) begin
					status_next = ST_MISSING;
				end
			end
			default: ;
		endcase
		if (!accept) begin
			ctrl.op    = CELL_HOLD;
			count_next = count_q;
		end
	end

	// Occupancy count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_next;
			data_q        <= data_next;
			entry_count_q <= count_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign data_out    = VALUE_W'(data_q);
	assign entry_count = entry_count_q;

endmodule

// ===== rtl/bdq_cell.sv =====
// One storage cell of the deque row: holds one entry and its valid bit.
`timescale 1ns / 1ps

module bdq_cell
	import bdq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic [DATA_WIDTH-1:0] left_value,
	input  logic                  left_valid,
	input  logic [DATA_WIDTH-1:0] right_value,
	input  logic                  right_valid,
	input  logic                  hit_in,
	output logic                  hit_out,
	output logic [DATA_WIDTH-1:0] tail_value,
	output logic [DATA_WIDTH-1:0] value_q,
	output logic                  valid_q
);

	logic match;
	logic is_tail;
	logic shift_fwd;

	// Compare against the broadcast key; hits ripple toward the back
	assign match     = valid_q && (value_q == ctrl.key);
	assign hit_out   = hit_in | match;
	assign is_tail   = valid_q && !right_valid;
	assign shift_fwd = hit_in | match;

	// Last occupied cell offers its value for a pop from the back
	assign tail_value = is_tail ? value_q : '0;

	// Entry payload, no reset needed
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_PUSH_FRONT: value_q <= left_value;
			CELL_PUSH_BACK: begin
				if (!valid_q && left_valid) begin
					value_q <= ctrl.key;
				end
			end
			CELL_POP_FRONT: value_q <= right_value;
			CELL_REMOVE: begin
				if (shift_fwd) begin
					value_q <= right_value;
				end
			end
			default: ;
		endcase
	end

	// Occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				CELL_PUSH_FRONT: valid_q <= left_valid;
				CELL_PUSH_BACK: begin
					if (!valid_q && left_valid) begin
						valid_q <= 1'b1;
					end
				end
				CELL_POP_FRONT: valid_q <= right_valid;
				CELL_POP_BACK: begin
					if (is_tail) begin
						valid_q <= 1'b0;
					end
				end
				CELL_REMOVE: begin
					if (shift_fwd) begin
						valid_q <= right_valid;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== tb/bounded_deque_with_remove_by_value_tb.sv =====
// Self-checking testbench for the bounded deque with remove-by-value and search.
`timescale 1ns / 1ps

module bounded_deque_with_remove_by_value_tb;
	import bdq_pkg::*;

	// Unused mode encodings, treated as no-ops by the block
	localparam logic [2:0] MODE_NOP_6 = 3'd6;
	localparam logic [2:0] MODE_NOP_7 = 3'd7;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLDOFF_CYCLES = 80;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] data;
		logic [CNT_W-1:0]   count;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         mode = MODE_PUSH_FRONT;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [VALUE_W-1:0] data_out;
	logic [CNT_W-1:0]   entry_count;

	bounded_deque_with_remove_by_value u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data_out    (data_out),
		.entry_count (entry_count)
	);

	always #6 clk = ~clk;

	// Shadow copy of the deque, front at index 0
	logic [VALUE_W-1:0] shadow_vals [CAPACITY];
	int                 shadow_count = 0;
	reply_t             pending_replies [$];

	int err_count = 0;
	int req_count = 0;
	int full_count = 0;
	int empty_count = 0;
	int miss_count = 0;
	int removed_count = 0;
	int deepest = 0;
	int cycle_cnt = 0;

	// Sender and receiver idling knobs
	int  gap_max = 0;
	int  burst_left = 0;
	int  stall_pct = 0;
	bit  holdoff_req = 0;
	int  holdoff_seen = 0;

	// Apply one request to the shadow deque and return the reply it should produce
	function automatic reply_t deque_predict(input logic [2:0] m, input logic [VALUE_W-1:0] v);
		reply_t r;
		int     i;
		int     pos;
		r.status = ST_OK;
		r.data   = '0;
		pos      = -1;
		case (m)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (m == MODE_PUSH_FRONT) begin
					for (i = shadow_count; i > 0; i--)
						shadow_vals[i] = shadow_vals[i-1];
					shadow_vals[0] = v;
					shadow_count++;
				end else begin
					shadow_vals[shadow_count] = v;
					shadow_count++;
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else if (m == MODE_POP_FRONT) begin
					r.data = shadow_vals[0];
					for (i = 0; i + 1 < shadow_count; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_count--;
				end else begin
					r.data = shadow_vals[shadow_count-1];
					shadow_count--;
				end
			end
			MODE_REMOVE, MODE_SEARCH: begin
				for (i = shadow_count - 1; i >= 0; i--)
					if (shadow_vals[i] == v)
						pos = i;
				if (pos < 0) begin
					r.status = ST_MISSING;
				end else if (m == MODE_REMOVE) begin
					for (i = pos; i + 1 < shadow_count; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_count--;
					removed_count++;
				end
			end
			default: ;
		endcase
		r.count = shadow_count[CNT_W-1:0];
		if (r.status == ST_FULL) full_count++;
		if (r.status == ST_EMPTY) empty_count++;
		if (r.status == ST_MISSING) miss_count++;
		if (shadow_count > deepest) deepest = shadow_count;
		return r;
	endfunction

	// Offer one request, honoring the burst/gap pattern, and record its reply
	task automatic send_request(input logic [2:0] m, input logic [VALUE_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode     <= m;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_replies.push_back(deque_predict(m, v));
		req_count++;
		burst_left--;
	endtask

	// Sender goes quiet until every outstanding reply has come back
	task automatic wait_for_responses();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	// Values mostly hit stored entries or a small pool so remove/search find matches
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (shadow_count > 0 && r < 40)
			return shadow_vals[$urandom_range(0, shadow_count - 1)];
		if (r < 70)
			return VALUE_W'($urandom_range(0, 7));
		return $urandom;
	endfunction

	// Receiver: runs of stall/go, plus a long hold-off on request
	initial begin : receiver
		int  run_left;
		int  hold_left;
		bit  stalling;
		run_left  = 0;
		hold_left = 0;
		stalling  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 0;
				hold_left   = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
				holdoff_seen++;
			end else begin
				if (run_left == 0) begin
					stalling = ($urandom_range(0, 99) < stall_pct);
					run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	// Reply checker: each accepted reply against the oldest prediction
	reply_t want;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply with none pending: status=%0d data=%h count=%0d",
					$time, status, data_out, entry_count);
				err_count++;
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, status);
					err_count++;
				end
				if (data_out !== want.data) begin
					$display("%0t: data_out mismatch: expected %h, actual %h",
						$time, want.data, data_out);
					err_count++;
				end
				if (entry_count !== want.count) begin
					$display("%0t: entry_count mismatch: expected %0d, actual %0d",
						$time, want.count, entry_count);
					err_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Pops, remove and search on an empty store, plus the no-op modes
	task automatic test_empty_store();
		send_request(MODE_POP_FRONT, 32'h1234_5678);
		send_request(MODE_POP_BACK, 32'hFFFF_FFFF);
		send_request(MODE_REMOVE, 32'd5);
		send_request(MODE_SEARCH, 32'd5);
		send_request(MODE_NOP_6, 32'hFFFF_FFFF);
		send_request(MODE_NOP_7, 32'h0);
	endtask

	// Fill to capacity with extremes and a duplicate, refuse pushes, then remove, search and pop at both ends
	task automatic test_fill_to_capacity();
		int i;
		send_request(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
		send_request(MODE_PUSH_BACK, 32'h0);
		send_request(MODE_PUSH_BACK, 32'd7);
		send_request(MODE_PUSH_FRONT, 32'd7);
		for (i = 0; i < CAPACITY - 4; i++)
			send_request(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
				(i[1] ? 32'h8000_0000 : 32'h5555_5555) ^ i);
		send_request(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
		send_request(MODE_PUSH_BACK, 32'hAAAA_AAAA);
		// duplicate: the entry nearest the front goes
		send_request(MODE_REMOVE, 32'd7);
		send_request(MODE_SEARCH, 32'd7);
		send_request(MODE_SEARCH, 32'hDEAD_BEEF);
		send_request(MODE_POP_FRONT, 32'h0);
		send_request(MODE_POP_BACK, 32'h0);
	endtask

	// Random requests; push/pop weights steer the fill level
	task automatic test_mixed_traffic(input int n, input int push_w, input int pop_w);
		int          k;
		int          r;
		logic [2:0]  m;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < push_w)
				m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
			else if (r < push_w + pop_w)
				m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
			else if (r < 96)
				m = $urandom_range(0, 1) ? MODE_REMOVE : MODE_SEARCH;
			else
				m = $urandom_range(0, 1) ? MODE_NOP_6 : MODE_NOP_7;
			send_request(m, pick_value());
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming
	task automatic test_output_holdoff();
		gap_max     = 0;
		stall_pct   = 0;
		holdoff_req = 1;
		test_mixed_traffic(60, 50, 30);
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed, no idling
		test_empty_store();
		test_fill_to_capacity();

		gap_max   = 3;
		stall_pct = 30;
		test_mixed_traffic(400, 45, 25);

		// push-heavy with no idling at all, runs into full refusals
		gap_max   = 0;
		stall_pct = 0;
		test_mixed_traffic(300, 70, 10);

		test_output_holdoff();
		wait_for_responses();

		// pop-heavy to drain and hit empty pops
		gap_max   = 4;
		stall_pct = 20;
		test_mixed_traffic(300, 15, 60);
		wait_for_responses();

		gap_max   = 6;
		stall_pct = 60;
		test_mixed_traffic(700, 40, 30);

		wait_for_responses();
		repeat (5) @(posedge clk);

		$display("Ran %0d requests: %0d full refusals, %0d empty pops, %0d misses, %0d removes.",
			req_count, full_count, empty_count, miss_count, removed_count);
		$display("Deepest fill %0d of %0d; receiver held off %0d cycles in one stretch.",
			deepest, CAPACITY, holdoff_seen);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
